FILE: hdl/slsm_pkg.sv
// Package for the sensor limit and stale monitor.
// Holds the parameter defaults, register indexes, table entry and sequencer types.
// Depends on nothing; the top level imports it.
package slsm_pkg;

   localparam int SENSORS_DEFAULT = 16;
   localparam int TICKS_DEFAULT   = 1000;

   typedef enum logic [1:0] {
      CSR_HIGH_LIMIT  = 2'd0,
      CSR_LOW_LIMIT   = 2'd1,
      CSR_RATE_LIMIT  = 2'd2,
      CSR_STALE_LIMIT = 2'd3
   } csr_index_type;

   localparam logic [31:0] HIGH_LIMIT_RESET  = 32'h7FFF_FFFF;
   localparam logic [31:0] LOW_LIMIT_RESET   = 32'h8000_0000;
   localparam logic [30:0] RATE_LIMIT_RESET  = 31'd0;
   localparam logic [15:0] STALE_LIMIT_RESET = 16'd3;
   localparam logic [15:0] STALE_COUNT_MAX   = 16'hFFFF;

   typedef struct packed {
      logic stale;
      logic high;
      logic low;
      logic rate;
   } flags_type;

   typedef struct packed {
      logic        primed;
      logic [31:0] value;
      logic [31:0] stamp;
      logic [31:0] rate;
      logic [15:0] count;
      flags_type   flags;
   } entry_type;

   typedef struct packed {
      logic stale;
      logic cleared;
      logic high;
      logic low;
      logic rate;
   } cause_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_MULT,
      ST_DIV,
      ST_FINISH,
      ST_EMIT2
   } state_type;

endpackage

FILE: hdl/sensor_limit_stale_monitor.sv
// Top level of the sensor limit and stale monitor: sequencer, sensor table,
// serial divider and register file.
// Depends on slsm_pkg.
//
// A check is one beat on the request channel: start is sampled while busy is low and
// carries sensor index, value and timestamp. Busy stays high while the check runs.
// An index of SENSORS or more is dropped at the beat and busy does not rise. A priming
// check, a check of an unprimed sensor and a repeated timestamp end after the read and
// evaluate states; a repeated timestamp gives at most one result, registered from the
// evaluate state. A fresh sample then passes a multiply state and a restoring divider,
// one quotient bit per cycle for 33 + clog2(TICKS_PER_SECOND) bits (43 for 1000 ticks),
// then a finish state, and an emit state when the check gives two results.
// Each result is shown for one cycle with rsp_valid high; a second result of the same
// check follows in the next cycle, and rsp_last_of_run marks the final one. The
// receiver cannot stall the result channel.
// Registers are written on the csr channel, which is always ready.
// Reset clears the sequencer, the result valid, the registers to their defaults and one
// valid bit per table entry, so every sensor starts unprimed at once with no clearing pass.
module sensor_limit_stale_monitor #(
   parameter int SENSORS          = slsm_pkg::SENSORS_DEFAULT,
   parameter int TICKS_PER_SECOND = slsm_pkg::TICKS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_sensor_index,
   input  logic signed [31:0] req_sample_value,
   input  logic [31:0]        req_sample_time,
   output logic               rsp_valid,
   output logic [3:0]         rsp_alarm_sensor,
   output logic               rsp_cause_stale,
   output logic               rsp_cause_cleared,
   output logic               rsp_cause_high,
   output logic               rsp_cause_low,
   output logic               rsp_cause_rate,
   output logic signed [31:0] rsp_alarm_value,
   output logic [31:0]        rsp_alarm_time,
   output logic               rsp_last_of_run,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import slsm_pkg::*;

   localparam int IW    = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   localparam int NUM_W = 33 + $clog2(TICKS_PER_SECOND);
   localparam int CW    = $clog2(NUM_W);

   state_type state_ff, state_in;

   logic signed [31:0] high_limit_ff;
   logic signed [31:0] low_limit_ff;
   logic [30:0]        rate_limit_ff;
   logic [15:0]        stale_limit_ff;

   logic [3:0]    idx_ff;
   logic [31:0]   val_ff;
   logic [31:0]   tim_ff;
   logic [IW-1:0] addr_ff;

   entry_type     mem [SENSORS];
   logic [SENSORS-1:0] vld_ff;
   entry_type     rd_ff;
   logic          rd_vld_ff;
   entry_type     ent;
   logic          wr_en;
   entry_type     wr_entry;

   logic             neg_ff, neg_in;
   logic [32:0]      mag_ff, mag_in;
   logic [31:0]      el_ff, el_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [31:0]      rem_ff, rem_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   logic      rsp_valid_ff, rsp_valid_in;
   cause_type cause_ff, cause_in;
   cause_type cause2_ff, cause2_in;
   logic      last_ff, last_in;

   logic [8:0]  idx_ext;
   logic        accept;
   logic        in_range;
   logic        same_time;
   logic [15:0] cnt_new;
   logic        stale_fire;
   logic signed [32:0] dv;
   logic [32:0] shifted;
   logic        ge;
   logic [32:0] diff;
   logic        rate_over;
   logic [31:0] rate_sat;
   flags_type   now_flags;
   logic        was_any;
   logic        now_any;
   logic        limit_any;
   cause_type   limit_cause;
   logic        two_results;

   assign accept    = start && !busy;
   assign idx_ext   = {5'd0, req_sensor_index};
   assign in_range  = idx_ext < 9'(SENSORS);
   assign ent       = rd_vld_ff ? rd_ff : '0;
   assign same_time = tim_ff == ent.stamp;
   assign cnt_new   = (ent.count < STALE_COUNT_MAX) ? ent.count + 16'd1 : ent.count;
   assign stale_fire = (cnt_new >= stale_limit_ff) && !ent.flags.stale;
   assign dv        = $signed({val_ff[31], val_ff}) - $signed({ent.value[31], ent.value});

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign ge      = shifted >= {1'b0, el_ff};
   assign diff    = shifted - {1'b0, el_ff};

   // The remainder settles the tie: |dv|*ticks > limit*elapsed exactly when the
   // quotient exceeds the limit, or equals it with a nonzero remainder.
   always_comb begin
      rate_over = 1'b0;
      if (rate_limit_ff != 31'd0) begin
         rate_over = (quo_ff > NUM_W'(rate_limit_ff)) ||
                     ((quo_ff == NUM_W'(rate_limit_ff)) && (rem_ff != 32'd0));
      end
      if (neg_ff) begin
         if (quo_ff > NUM_W'(33'h0_8000_0000)) begin
            rate_sat = 32'd0 - 32'h8000_0000;
         end else begin
            rate_sat = 32'd0 - quo_ff[31:0];
         end
      end else begin
         if (quo_ff > NUM_W'(33'h0_7FFF_FFFF)) begin
            rate_sat = 32'h7FFF_FFFF;
         end else begin
            rate_sat = quo_ff[31:0];
         end
      end
      now_flags.stale = 1'b0;
      now_flags.high  = $signed(val_ff) > high_limit_ff;
      now_flags.low   = $signed(val_ff) < low_limit_ff;
      now_flags.rate  = rate_over;
      was_any = ent.flags.high || ent.flags.low || ent.flags.rate;
      now_any = now_flags.high || now_flags.low || now_flags.rate;
      limit_cause = '0;
      limit_any   = 1'b0;
      if (!was_any && now_any) begin
         limit_cause.high = now_flags.high;
         limit_cause.low  = now_flags.low;
         limit_cause.rate = now_flags.rate;
         limit_any = 1'b1;
      end else if (was_any && !now_any) begin
         limit_cause.cleared = 1'b1;
         limit_any = 1'b1;
      end
      two_results = ent.flags.stale && limit_any;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && in_range) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            if (!ent.primed || same_time) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == CW'(NUM_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = two_results ? ST_EMIT2 : ST_IDLE;
         ST_EMIT2:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wr_en        = 1'b0;
      wr_entry     = ent;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      el_in        = el_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      cause_in     = cause_ff;
      cause2_in    = cause2_ff;
      last_in      = last_ff;
      unique case (state_ff)
         ST_EVAL: begin
            if (!ent.primed) begin
               wr_en           = tim_ff != 32'd0;
               wr_entry.primed = 1'b1;
               wr_entry.value  = val_ff;
               wr_entry.stamp  = tim_ff;
            end else if (same_time) begin
               wr_en          = 1'b1;
               wr_entry.count = cnt_new;
               if (stale_fire) begin
                  wr_entry.flags       = '0;
                  wr_entry.flags.stale = 1'b1;
                  rsp_valid_in         = 1'b1;
                  cause_in             = '0;
                  cause_in.stale       = 1'b1;
                  last_in              = 1'b1;
               end
            end else begin
               neg_in = dv[32];
               mag_in = dv[32] ? 33'(-dv) : 33'(dv);
               el_in  = tim_ff - ent.stamp;
               rem_in = 32'd0;
               cnt_in = '0;
            end
         end
         ST_MULT: begin
            quo_in = NUM_W'(NUM_W'(mag_ff) * NUM_W'(TICKS_PER_SECOND));
         end
         ST_DIV: begin
            rem_in = ge ? diff[31:0] : shifted[31:0];
            quo_in = {quo_ff[NUM_W-2:0], ge};
            cnt_in = cnt_ff + CW'(1);
         end
         ST_FINISH: begin
            wr_en          = 1'b1;
            wr_entry.value = val_ff;
            wr_entry.stamp = tim_ff;
            wr_entry.rate  = rate_sat;
            wr_entry.count = 16'd0;
            wr_entry.flags = now_flags;
            cause2_in      = limit_cause;
            if (ent.flags.stale) begin
               rsp_valid_in     = 1'b1;
               cause_in         = '0;
               cause_in.cleared = 1'b1;
               last_in          = !limit_any;
            end else if (limit_any) begin
               rsp_valid_in = 1'b1;
               cause_in     = limit_cause;
               last_in      = 1'b1;
            end
         end
         ST_EMIT2: begin
            rsp_valid_in = 1'b1;
            cause_in     = cause2_ff;
            last_in      = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         vld_ff         <= '0;
         high_limit_ff  <= HIGH_LIMIT_RESET;
         low_limit_ff   <= LOW_LIMIT_RESET;
         rate_limit_ff  <= RATE_LIMIT_RESET;
         stale_limit_ff <= STALE_LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            vld_ff[addr_ff] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_HIGH_LIMIT:  high_limit_ff  <= csr_data;
               CSR_LOW_LIMIT:   low_limit_ff   <= csr_data;
               CSR_RATE_LIMIT:  rate_limit_ff  <= csr_data[30:0];
               CSR_STALE_LIMIT: stale_limit_ff <= csr_data[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff  <= req_sensor_index;
         val_ff  <= req_sample_value;
         tim_ff  <= req_sample_time;
         addr_ff <= idx_ext[IW-1:0];
      end
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      el_ff     <= el_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      cause_ff  <= cause_in;
      cause2_ff <= cause2_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr_ff] <= wr_entry;
      end
      rd_ff     <= mem[addr_ff];
      rd_vld_ff <= vld_ff[addr_ff];
   end

   assign busy              = state_ff != ST_IDLE;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_alarm_sensor  = idx_ff;
   assign rsp_cause_stale   = cause_ff.stale;
   assign rsp_cause_cleared = cause_ff.cleared;
   assign rsp_cause_high    = cause_ff.high;
   assign rsp_cause_low     = cause_ff.low;
   assign rsp_cause_rate    = cause_ff.rate;
   assign rsp_alarm_value   = val_ff;
   assign rsp_alarm_time    = tim_ff;
   assign rsp_last_of_run   = last_ff;

   // A result that is not the last of its check is followed by the other one at once.
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |=> (rsp_valid && rsp_last_of_run))
      else $error("second result of a check did not follow");

   // Every result carries exactly one kind of cause.
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_cause_stale, rsp_cause_cleared,
                             rsp_cause_high || rsp_cause_low || rsp_cause_rate}))
      else $error("result without exactly one kind of cause");

   // A stale alarm is always the only result of its check.
   a_stale_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cause_stale) |-> rsp_last_of_run)
      else $error("stale alarm not the last result");

   // No result appears in the cycle after a new check is taken.
   a_no_result_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result right after a new check was taken");

endmodule
